@@ rtl/ypdt_pkg.sv @@
// shared types and constants for the yaw pid differential thrust unit
`default_nettype none

package ypdt_pkg;

  // heading in 1/64 degree
  localparam int HALF_TURN     = 11520;
  localparam int FULL_TURN     = 23040;
  localparam int OFFSET_SAMPLE = 5;
  localparam int COUNT_MAX     = 20;

  // thrust dead-band, q8.8
  localparam int STILL_OFFSET = 538;
  localparam int MOVE_OFFSET  = 1126;
  localparam int MOVE_LIMIT   = 563;
  localparam int THRUST_MAX   = 8388607;
  localparam int THRUST_MIN   = -8388608;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0,
    CFG_TARGET = 3'd1,
    CFG_SPEED  = 3'd2,
    CFG_GAIN_P = 3'd3,
    CFG_GAIN_I = 3'd4,
    CFG_GAIN_D = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] heading_raw;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic        [14:0] heading;
    logic signed [23:0] left_thrust;
    logic signed [23:0] right_thrust;
  } out_word_t;

  typedef struct packed {
    logic               enable;
    logic        [14:0] target_heading;
    logic signed [15:0] forward_speed;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } cfg_t;

  // what travels alongside the arithmetic through every stage
  typedef struct packed {
    logic        kind;
    logic [14:0] heading;
    logic        active;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [15:0] err;
    logic signed [31:0] integ;
    logic signed [16:0] diff;
  } front_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [31:0] prod_p;
    logic signed [47:0] prod_i;
    logic signed [32:0] prod_d;
  } prod_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [43:0] pid;
  } sum_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } stage_load_t;

endpackage

`default_nettype wire

@@ rtl/yaw_pid_differential_thrust_unit.sv @@
// top level: heading-hold pid with differential thrust output
// latency: an accepted word passes the front, product, sum and result registers to out_data
// throughput: one word per cycle while out_ready is high; four stages, each able to stall
// the heading and integrator state update in the accept cycle, so back-to-back words chain
// reset (synchronous, active high) empties the pipeline and clears the controller state;
// target heading resets to 180 degrees, the other config fields and state to zero
`default_nettype none

module yaw_pid_differential_thrust_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ypdt_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ypdt_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  ypdt_pkg::cfg_t        cfg;
  ypdt_pkg::front_t      front;
  ypdt_pkg::sum_t        sum;
  ypdt_pkg::stage_load_t load;

  logic valid_a, valid_b, valid_c, valid_d;
  logic ready_a, ready_b, ready_c, ready_d;

  // a stage takes a new word when empty or when its word moves on
  always_comb begin
    ready_d = !valid_d || out_ready;
    ready_c = !valid_c || ready_d;
    ready_b = !valid_b || ready_c;
    ready_a = !valid_a || ready_b;
    load.a  = in_valid && ready_a;
    load.b  = valid_a && ready_b;
    load.c  = valid_b && ready_c;
    load.d  = valid_c && ready_d;
  end

  assign in_ready  = ready_a;
  assign out_valid = valid_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (ready_a) valid_a <= in_valid;
      if (ready_b) valid_b <= valid_a;
      if (ready_c) valid_c <= valid_b;
      if (ready_d) valid_d <= valid_c;
    end
  end

  ypdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ypdt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .load    (load.a),
    .in_data (in_data),
    .cfg     (cfg),
    .front   (front)
  );

  ypdt_pid u_pid (
    .clk       (clk),
    .load_prod (load.b),
    .load_sum  (load.c),
    .front     (front),
    .cfg       (cfg),
    .sum       (sum)
  );

  ypdt_mix u_mix (
    .clk           (clk),
    .load          (load.d),
    .sum           (sum),
    .forward_speed (cfg.forward_speed),
    .out_word      (out_data)
  );

  a_report_no_thrust: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == ypdt_pkg::CMD_SAMPLE) |->
      (out_data.left_thrust == 24'sd0 && out_data.right_thrust == 24'sd0))
    else $error("heading report carries thrust");

endmodule

`default_nettype wire

@@ rtl/ypdt_cfg.sv @@
// configuration register file
`default_nettype none

module ypdt_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data,
  output ypdt_pkg::cfg_t      cfg
);

  ypdt_pkg::cfg_t cfg_q;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.target_heading <= 15'(ypdt_pkg::HALF_TURN);
      cfg_q.forward_speed  <= '0;
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ypdt_pkg::cfg_index_t'(cfg_index))
        ypdt_pkg::CFG_ENABLE: cfg_q.enable         <= cfg_data[0];
        ypdt_pkg::CFG_TARGET: cfg_q.target_heading <= cfg_data[14:0];
        ypdt_pkg::CFG_SPEED:  cfg_q.forward_speed  <= $signed(cfg_data);
        ypdt_pkg::CFG_GAIN_P: cfg_q.gain_p         <= $signed(cfg_data);
        ypdt_pkg::CFG_GAIN_I: cfg_q.gain_i         <= $signed(cfg_data);
        ypdt_pkg::CFG_GAIN_D: cfg_q.gain_d         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ypdt_front.sv @@
// heading and integrator state, first pipeline register
`default_nettype none

module ypdt_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire ypdt_pkg::in_word_t in_data,
  input  wire ypdt_pkg::cfg_t     cfg,
  output ypdt_pkg::front_t        front
);

  logic        [4:0]  sample_count;
  logic signed [15:0] heading_offset;
  logic        [14:0] current_heading;
  logic signed [31:0] error_integral;
  logic signed [15:0] last_error;
  ypdt_pkg::front_t   front_q;

  logic signed [15:0] raw;
  logic signed [15:0] offset_use;
  logic signed [17:0] d0, d1, d2, d3;
  logic        [14:0] heading_next;
  logic signed [15:0] err;
  logic signed [32:0] sum;
  logic signed [31:0] integ_next;
  logic signed [16:0] diff;
  logic               is_sample;
  logic               active;
  logic               take_offset;

  always_comb begin
    raw         = $signed(in_data.heading_raw);
    take_offset = (sample_count == 5'(ypdt_pkg::OFFSET_SAMPLE));
    offset_use  = take_offset ? raw : heading_offset;
    // re-centre, one wrap each way, then clamp
    d0 = 18'(raw) - 18'(offset_use) + 18'(ypdt_pkg::HALF_TURN);
    d1 = (d0 < 18'sd0) ? d0 + 18'(ypdt_pkg::FULL_TURN) : d0;
    d2 = (d1 > 18'(ypdt_pkg::FULL_TURN)) ? d1 - 18'(ypdt_pkg::FULL_TURN) : d1;
    if (d2 < 18'sd0) begin
      d3 = 18'sd0;
    end else if (d2 > 18'(ypdt_pkg::FULL_TURN)) begin
      d3 = 18'(ypdt_pkg::FULL_TURN);
    end else begin
      d3 = d2;
    end
    heading_next = d3[14:0];

    is_sample = (in_data.cmd == ypdt_pkg::CMD_SAMPLE);
    active    = (in_data.cmd == ypdt_pkg::CMD_TICK) && cfg.enable;

    err  = $signed({1'b0, cfg.target_heading}) - $signed({1'b0, current_heading});
    sum  = 33'(error_integral) + 33'(err);
    // saturate integral to 32-bit signed
    if (sum[32] != sum[31]) begin
      integ_next = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_next = sum[31:0];
    end
    diff = 17'(err) - 17'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      heading_offset  <= '0;
      current_heading <= '0;
      error_integral  <= '0;
      last_error      <= '0;
    end else if (load) begin
      if (is_sample) begin
        if (take_offset) begin
          heading_offset <= raw;
        end
        if (sample_count < 5'(ypdt_pkg::COUNT_MAX)) begin
          sample_count <= sample_count + 5'd1;
        end
        current_heading <= heading_next;
      end else if (active) begin
        error_integral <= integ_next;
        last_error     <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_q.tag.kind    <= in_data.cmd;
      front_q.tag.heading <= is_sample ? heading_next : current_heading;
      front_q.tag.active  <= active;
      front_q.err         <= err;
      front_q.integ       <= integ_next;
      front_q.diff        <= diff;
    end
  end

  assign front = front_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= 5'(ypdt_pkg::COUNT_MAX))
    else $error("sample count past its limit");

  a_heading_bound: assert property (@(posedge clk) disable iff (rst)
    current_heading <= 15'(ypdt_pkg::FULL_TURN))
    else $error("stored heading out of range");

  a_offset_capture: assert property (@(posedge clk) disable iff (rst)
    (load && is_sample && take_offset) |=>
      (heading_offset == $past(in_data.heading_raw) &&
       current_heading == 15'(ypdt_pkg::HALF_TURN)))
    else $error("zero offset not taken on the sixth sample");

endmodule

`default_nettype wire

@@ rtl/ypdt_pid.sv @@
// pid products and their sum, two pipeline registers
`default_nettype none

module ypdt_pid (
  input  wire logic             clk,
  input  wire logic             load_prod,
  input  wire logic             load_sum,
  input  wire ypdt_pkg::front_t front,
  input  wire ypdt_pkg::cfg_t   cfg,
  output ypdt_pkg::sum_t        sum
);

  ypdt_pkg::prod_t    prod_q;
  ypdt_pkg::sum_t     sum_q;
  logic signed [49:0] total;

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_q.tag    <= front.tag;
      prod_q.prod_p <= $signed(cfg.gain_p) * $signed(front.err);
      prod_q.prod_i <= 48'($signed(cfg.gain_i)) * 48'($signed(front.integ));
      prod_q.prod_d <= 33'($signed(cfg.gain_d)) * 33'($signed(front.diff));
    end
  end

  always_comb begin
    total = 50'($signed(prod_q.prod_p)) + 50'($signed(prod_q.prod_i))
          + 50'($signed(prod_q.prod_d));
  end

  always_ff @(posedge clk) begin
    if (load_sum) begin
      sum_q.tag <= prod_q.tag;
      // arithmetic shift gives the floor of total / 64
      sum_q.pid <= total[49:6];
    end
  end

  assign sum = sum_q;

endmodule

`default_nettype wire

@@ rtl/ypdt_mix.sv @@
// differential split, dead-band and saturation into the result register
`default_nettype none

module ypdt_mix (
  input  wire logic           clk,
  input  wire logic           load,
  input  wire ypdt_pkg::sum_t sum,
  input  wire logic signed [15:0] forward_speed,
  output ypdt_pkg::out_word_t out_word
);

  ypdt_pkg::out_word_t out_q;
  logic signed [46:0]  left_raw, right_raw;
  logic signed [23:0]  left_sat, right_sat;
  logic                speed_zero, speed_pos;

  function automatic logic signed [23:0] shape(input logic signed [46:0] v,
                                               input logic zero, input logic pos);
    logic signed [46:0] t;
    begin
      t = v;
      if (zero) begin
        if (v < 47'sd0) begin
          t = v - 47'(ypdt_pkg::STILL_OFFSET);
        end else if (v > 47'sd0) begin
          t = v + 47'(ypdt_pkg::STILL_OFFSET);
        end
      end else if (pos) begin
        if (v <= 47'(ypdt_pkg::MOVE_LIMIT)) begin
          t = v - 47'(ypdt_pkg::MOVE_OFFSET);
        end
      end
      if (t > 47'(ypdt_pkg::THRUST_MAX)) begin
        shape = 24'(ypdt_pkg::THRUST_MAX);
      end else if (t < 47'(ypdt_pkg::THRUST_MIN)) begin
        shape = 24'(ypdt_pkg::THRUST_MIN);
      end else begin
        shape = t[23:0];
      end
    end
  endfunction

  always_comb begin
    speed_zero = (forward_speed == 16'sd0);
    speed_pos  = !forward_speed[15] && !speed_zero;
    left_raw   = 47'(forward_speed) - 47'($signed(sum.pid));
    right_raw  = 47'(forward_speed) + 47'($signed(sum.pid));
    left_sat   = shape(left_raw, speed_zero, speed_pos);
    right_sat  = shape(right_raw, speed_zero, speed_pos);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q.kind         <= sum.tag.kind;
      out_q.heading      <= sum.tag.heading;
      out_q.left_thrust  <= sum.tag.active ? left_sat : 24'sd0;
      out_q.right_thrust <= sum.tag.active ? right_sat : 24'sd0;
    end
  end

  assign out_word = out_q;

endmodule

`default_nettype wire

@@ bench/tb_yaw_pid_differential_thrust_unit.sv @@
// testbench for the yaw pid differential thrust unit: predicted words checked in order
`default_nettype none

module tb_yaw_pid_differential_thrust_unit;

  // indexes that decode to no register
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int IDLE_PCT = 23;
  localparam int DRAIN_CYCLES = 16;
  localparam int SWING_TICKS = 30;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF;
  localparam longint SUM_MIN = -64'sh8000_0000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ypdt_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ypdt_pkg::out_word_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  // shadow registers
  logic loop_on = 1'b0;
  int   tgt_hdg = ypdt_pkg::HALF_TURN;
  int   fwd_speed = 0;
  int   kp = 0;
  int   ki = 0;
  int   kd = 0;

  // shadow controller state
  int samples_seen = 0;
  int hdg_offset = 0;
  int hdg_now = 0;
  int err_sum = 0;
  int err_prev = 0;

  ypdt_pkg::out_word_t pending_reports[$];
  int mismatch_count = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int offset_raw = 0;

  yaw_pid_differential_thrust_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      ypdt_pkg::CFG_ENABLE: loop_on = val[0];
      ypdt_pkg::CFG_TARGET: tgt_hdg = int'(val[14:0]);
      ypdt_pkg::CFG_SPEED:  fwd_speed = int'(signed'(val));
      ypdt_pkg::CFG_GAIN_P: kp = int'(signed'(val));
      ypdt_pkg::CFG_GAIN_I: ki = int'(signed'(val));
      ypdt_pkg::CFG_GAIN_D: kd = int'(signed'(val));
      default: ;
    endcase
  endfunction

  function automatic ypdt_pkg::out_word_t heading_thrust_report(input ypdt_pkg::in_word_t w);
    ypdt_pkg::out_word_t r;
    int raw, d, err, diff;
    longint acc, pid, lt, rt;
    r = '0;
    r.kind = w.cmd;
    if (w.cmd == ypdt_pkg::CMD_SAMPLE) begin
      raw = int'(w.heading_raw);
      if (samples_seen == ypdt_pkg::OFFSET_SAMPLE) hdg_offset = raw;
      d = raw - hdg_offset + ypdt_pkg::HALF_TURN;
      if (samples_seen < ypdt_pkg::COUNT_MAX) samples_seen++;
      // one wrap only, then clamp
      if (d < 0) d += ypdt_pkg::FULL_TURN;
      if (d > ypdt_pkg::FULL_TURN) d -= ypdt_pkg::FULL_TURN;
      if (d < 0) d = 0;
      if (d > ypdt_pkg::FULL_TURN) d = ypdt_pkg::FULL_TURN;
      hdg_now = d;
    end else if (loop_on) begin
      err = tgt_hdg - hdg_now;
      acc = longint'(err_sum) + err;
      if (acc > SUM_MAX) acc = SUM_MAX;
      if (acc < SUM_MIN) acc = SUM_MIN;
      err_sum = int'(acc);
      diff = err - err_prev;
      err_prev = err;
      // floor towards minus infinity when scaling back to q8.8
      pid = (longint'(kp) * err + longint'(ki) * err_sum + longint'(kd) * diff) >>> 6;
      lt = longint'(fwd_speed) - pid;
      rt = longint'(fwd_speed) + pid;
      if (fwd_speed == 0) begin
        if (lt < 0) lt -= ypdt_pkg::STILL_OFFSET;
        else if (lt > 0) lt += ypdt_pkg::STILL_OFFSET;
        if (rt < 0) rt -= ypdt_pkg::STILL_OFFSET;
        else if (rt > 0) rt += ypdt_pkg::STILL_OFFSET;
      end else if (fwd_speed > 0) begin
        if (lt <= ypdt_pkg::MOVE_LIMIT) lt -= ypdt_pkg::MOVE_OFFSET;
        if (rt <= ypdt_pkg::MOVE_LIMIT) rt -= ypdt_pkg::MOVE_OFFSET;
      end
      if (lt > ypdt_pkg::THRUST_MAX) lt = ypdt_pkg::THRUST_MAX;
      if (lt < ypdt_pkg::THRUST_MIN) lt = ypdt_pkg::THRUST_MIN;
      if (rt > ypdt_pkg::THRUST_MAX) rt = ypdt_pkg::THRUST_MAX;
      if (rt < ypdt_pkg::THRUST_MIN) rt = ypdt_pkg::THRUST_MIN;
      r.left_thrust = lt[23:0];
      r.right_thrust = rt[23:0];
    end
    r.heading = hdg_now[14:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_report(input ypdt_pkg::out_word_t got);
    ypdt_pkg::out_word_t want;
    if (pending_reports.size() == 0) begin
      mismatch_count++;
      $display("%0t: word with nothing expected, expected none, got kind %0d heading %0d",
               $time, got.kind, got.heading);
    end else begin
      want = pending_reports.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("heading", 32'(want.heading), 32'(got.heading));
      check_field("left_thrust", 32'(want.left_thrust), 32'(got.left_thrust));
      check_field("right_thrust", 32'(want.right_thrust), 32'(got.right_thrust));
    end
  endfunction

  // receiver: random stalls, or a counted hold-off when asked
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) check_report(out_data);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req <= 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic ypdt_pkg::in_word_t sample_word(input int raw);
    ypdt_pkg::in_word_t w;
    w.cmd = ypdt_pkg::CMD_SAMPLE;
    w.heading_raw = raw[15:0];
    return w;
  endfunction

  function automatic ypdt_pkg::in_word_t tick_word();
    ypdt_pkg::in_word_t w;
    w.cmd = ypdt_pkg::CMD_TICK;
    w.heading_raw = 16'($urandom);
    return w;
  endfunction

  function automatic logic signed [15:0] pick_q88(input int mag);
    case ($urandom_range(5))
      0: return '0;
      1: return 16'($urandom);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(int'($urandom_range(2 * mag)) - mag);
    endcase
  endfunction

  // valid is left high after acceptance so the next word can follow at once
  task automatic send_word(input ypdt_pkg::in_word_t w);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(heading_thrust_report(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    if (last) cfg_valid <= 1'b0;
  endtask

  // unused data bits carry junk so every bit of the write word toggles
  task automatic load_config(input ypdt_pkg::cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom);
    wait_drained();
    write_reg(ypdt_pkg::CFG_ENABLE, {junk[15:1], c.enable}, 1'b0);
    write_reg(ypdt_pkg::CFG_TARGET, {junk[0], c.target_heading}, 1'b0);
    write_reg(ypdt_pkg::CFG_SPEED, c.forward_speed, 1'b0);
    write_reg(ypdt_pkg::CFG_GAIN_P, c.gain_p, 1'b0);
    write_reg(ypdt_pkg::CFG_GAIN_I, c.gain_i, 1'b0);
    write_reg(ypdt_pkg::CFG_GAIN_D, c.gain_d, 1'b1);
  endtask

  // reset registers, the five samples before the offset, the offset, then clamping
  task automatic test_offset_capture();
    offset_raw = $urandom_range(1) ? 16384 : -16384;
    send_word(tick_word());
    send_word(sample_word(-32768));
    send_word(sample_word(32767));
    send_word(sample_word(ypdt_pkg::HALF_TURN));
    send_word(sample_word(-ypdt_pkg::HALF_TURN));
    send_word(sample_word(0));
    send_word(sample_word(offset_raw));
    send_word(sample_word(offset_raw + ypdt_pkg::HALF_TURN));
    send_word(sample_word(offset_raw - ypdt_pkg::HALF_TURN));
    send_word(sample_word(32767));
    send_word(sample_word(-32768));
    send_word(tick_word());
  endtask

  task automatic test_tick_cases();
    ypdt_pkg::cfg_t c;
    c = '0;
    c.enable = 1'b1;
    c.target_heading = 15'(ypdt_pkg::HALF_TURN);
    load_config(c);
    send_word(sample_word(offset_raw - ypdt_pkg::HALF_TURN));
    send_word(tick_word());
    // still: dead-band pushes both sides away from zero
    c.gain_p = 16'sd64;
    c.gain_d = -16'sd64;
    load_config(c);
    send_word(tick_word());
    // moving forward with a slow side
    c.forward_speed = 16'sd256;
    c.gain_p = 16'sd16;
    c.gain_d = '0;
    load_config(c);
    send_word(tick_word());
    send_word(tick_word());
    c.forward_speed = -16'sd256;
    load_config(c);
    send_word(tick_word());
    c.target_heading = 15'd0;
    c.forward_speed = '0;
    load_config(c);
    send_word(tick_word());
    // target above a full turn, everything at the top end
    c.target_heading = 15'h7FFF;
    c.forward_speed = 16'sh7FFF;
    c.gain_p = 16'sh7FFF;
    c.gain_i = 16'sh7FFF;
    c.gain_d = 16'sh7FFF;
    load_config(c);
    send_word(tick_word());
    send_word(tick_word());
    c.forward_speed = 16'sh8000;
    c.gain_p = 16'sh8000;
    c.gain_i = 16'sh8000;
    c.gain_d = 16'sh8000;
    load_config(c);
    send_word(tick_word());
    send_word(tick_word());
    c.enable = 1'b0;
    load_config(c);
    send_word(tick_word());
    // writes to spare indexes must leave speed and gains alone
    c.enable = 1'b1;
    c.target_heading = 15'(ypdt_pkg::HALF_TURN);
    c.forward_speed = 16'sd100;
    c.gain_p = 16'sd8;
    c.gain_i = '0;
    c.gain_d = '0;
    load_config(c);
    send_word(tick_word());
    wait_drained();
    write_reg(CFG_SPARE_LO, 16'hFFFF, 1'b0);
    write_reg(CFG_SPARE_HI, 16'h8000, 1'b0);
    write_reg(ypdt_pkg::CFG_ENABLE, 16'h0001, 1'b1);
    send_word(tick_word());
  endtask

  task automatic test_random_phases();
    ypdt_pkg::cfg_t c;
    int p, i;
    for (p = 0; p < 6; p++) begin
      c.enable = ($urandom_range(7) != 0);
      c.target_heading = ($urandom_range(7) == 0) ? 15'($urandom_range(32767))
                                                   : 15'($urandom_range(ypdt_pkg::FULL_TURN));
      c.forward_speed = pick_q88(1024);
      c.gain_p = pick_q88(256);
      c.gain_i = pick_q88(8);
      c.gain_d = pick_q88(512);
      load_config(c);
      quiet = (p == 1);
      // long receiver hold-off so the pipeline fills and backs up the input
      if (p == 2) hold_req <= 200;
      for (i = 0; i < 250; i++) begin
        if (p == 3 && i == 125) wait_drained();
        send_word(($urandom_range(99) < 35) ? sample_word($urandom) : tick_word());
      end
    end
    quiet = 1'b0;
  endtask

  // push the integrator hard one way, then the other
  task automatic test_integral_swing();
    ypdt_pkg::cfg_t c;
    c = '0;
    c.enable = 1'b1;
    c.target_heading = 15'h7FFF;
    c.gain_i = 16'sd1;
    load_config(c);
    quiet = 1'b1;
    send_word(sample_word(offset_raw - ypdt_pkg::HALF_TURN));
    repeat (SWING_TICKS) send_word(tick_word());
    c.target_heading = 15'd0;
    load_config(c);
    send_word(sample_word(offset_raw + ypdt_pkg::HALF_TURN));
    repeat (2 * SWING_TICKS) send_word(tick_word());
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_offset_capture();
    test_tick_cases();
    test_random_phases();
    test_integral_swing();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("PASS yaw_pid_differential_thrust_unit");
    end else begin
      $display("FAIL yaw_pid_differential_thrust_unit");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL yaw_pid_differential_thrust_unit");
    $finish;
  end

endmodule

`default_nettype wire
